// File: rtl/dtq_pkg.sv
// Package for the deadline timer queue: field widths, time constants, action and
// status codes, and the state, command and status types of the controller.
// No dependencies. Every other file of the block imports it.
package dtq_pkg;

    localparam int DL_W        = 64;
    localparam int NOW_W       = 63;
    localparam int DELAY_W     = 32;
    localparam int MS_W        = 32;
    localparam int ID_W        = 5;
    localparam int NS_W        = 20;
    localparam int PROD_W      = DELAY_W + NS_W;
    localparam int TUSER_W     = 2;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 80;

    // One millisecond is 15625 << 6 nanoseconds; the odd factor is divided by a
    // reciprocal multiplication.
    localparam int LOW_W       = 6;
    localparam int ODD_W       = 14;
    localparam int QX_W        = 46;
    localparam int REM_W       = 17;
    localparam int RECIP_SHIFT = 31;

    localparam logic [NS_W-1:0]  NS_PER_MS = 20'd1000000;
    localparam logic [MS_W-1:0]  MS_MAX    = 32'hFFFF_FFFF;
    localparam logic [DL_W-1:0]  SAT_NS    = 64'd4294967295000000;
    localparam logic [ODD_W-1:0] MS_ODD    = 14'd15625;
    localparam logic [MS_W-1:0]  MS_RECIP  = 32'd2251799813;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_END   = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_WAKE  = 2'd3
    } dtq_action_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_ALREADY     = 2'd1,
        ST_NOT_WAITING = 2'd2
    } dtq_status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_CHECK,
        S_SCAN1,
        S_SCAN2,
        S_DIV,
        S_OUT
    } dtq_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_REM,
        DV_FIN
    } dtq_div_state_t;

    typedef enum logic {
        SRC_ENTRY,
        SRC_BEST
    } dtq_div_src_t;

    typedef struct packed {
        logic         in_ready;
        logic         clr_wr;
        logic         look;
        logic         set_entry;
        logic         unwait;
        logic         cap_entry;
        logic         scan_start;
        logic         div_start;
        dtq_div_src_t div_src;
        logic         set_status;
        dtq_status_t  status_code;
        logic         set_tvalid;
        logic         set_wake;
        logic         store_div;
        logic         out_load;
    } dtq_cmd_t;

    typedef struct packed {
        logic        clr_done;
        logic        in_valid;
        dtq_action_t act;
        logic        in_range;
        logic        ent_waiting;
        logic        scan_busy;
        logic        was_first;
        logic        best_valid;
        logic        div_busy;
        logic        out_free;
    } dtq_stat_t;

endpackage

// File: rtl/dtq_ms_div.sv
// Converts a nanosecond difference into whole milliseconds, rounded up and
// saturated, by a reciprocal multiplication and a small correction in DV_MUL, DV_REM and DV_FIN.
// Depends on dtq_pkg.
module dtq_ms_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [dtq_pkg::DL_W-1:0] d,
    output logic                   busy,
    output logic [dtq_pkg::MS_W-1:0] ms
);
    import dtq_pkg::*;

    dtq_div_state_t    state_reg;
    dtq_div_state_t    state_next;
    logic [DL_W-1:0]   d_reg;
    logic              sat_reg;
    logic [MS_W-1:0]   q_reg;
    logic [REM_W-1:0]  r_reg;
    logic [MS_W-1:0]   ms_reg;
    logic [DL_W-1:0]   prod;
    logic [QX_W-1:0]   q_mul;
    logic [2:0]        fix;
    logic              exact;

    // The estimate from the top 32 bits falls short of the quotient by at most four.
    assign prod  = DL_W'(d_reg[LOW_W+QX_W-1:LOW_W+ODD_W]) * DL_W'(MS_RECIP);
    assign q_mul = QX_W'(q_reg) * QX_W'(MS_ODD);
    assign fix   = 3'(r_reg >= REM_W'(MS_ODD))
                 + 3'(r_reg >= REM_W'(2 * MS_ODD))
                 + 3'(r_reg >= REM_W'(3 * MS_ODD))
                 + 3'(r_reg >= REM_W'(4 * MS_ODD));
    assign exact = (r_reg == REM_W'(fix) * REM_W'(MS_ODD)) && (d_reg[LOW_W-1:0] == '0);
    assign ms    = ms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    state_next = DV_MUL;
                end
            end
            DV_MUL:
            begin
                state_next = DV_REM;
            end
            DV_REM:
            begin
                state_next = DV_FIN;
            end
            DV_FIN:
            begin
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            DV_IDLE: busy = 1'b0;
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    d_reg <= d;
                end
            end
            DV_MUL:
            begin
                sat_reg <= (d_reg > SAT_NS);
                q_reg   <= prod[RECIP_SHIFT+MS_W-1:RECIP_SHIFT];
            end
            DV_REM:
            begin
                r_reg <= REM_W'(d_reg[LOW_W+QX_W-1:LOW_W] - q_mul);
            end
            DV_FIN:
            begin
                ms_reg <= sat_reg ? MS_MAX : (q_reg + MS_W'(fix) + MS_W'(!exact));
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: rtl/dtq_datapath.sv
// Datapath of the deadline timer queue: task slot memory, clearing pass, slot scan
// for the earliest deadline, millisecond divider, result and output registers.
// Depends on dtq_pkg and dtq_ms_div.
module dtq_datapath #(
    parameter int TASK_SLOTS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dtq_pkg::dtq_cmd_t                   cmd,
    output dtq_pkg::dtq_stat_t                  stat,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dtq_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic [dtq_pkg::TUSER_W-1:0]         s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dtq_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import dtq_pkg::*;

    localparam int IDX_W = $clog2(TASK_SLOTS);

    logic [DL_W:0]            slot_mem [TASK_SLOTS];
    logic [DL_W:0]            rd_data_reg;
    logic [IDX_W-1:0]         rd_addr;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [DL_W:0]            wr_data;

    dtq_action_t              act_reg;
    logic [ID_W-1:0]          id_reg;
    logic [NOW_W-1:0]         now_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [DL_W-1:0]          ent_dl_reg;
    logic [IDX_W-1:0]         id_addr;
    logic [DL_W-1:0]          now64;
    logic [DL_W-1:0]          new_dl;
    logic                     in_fire;

    logic [IDX_W-1:0]         clr_cnt_reg;

    logic                     scan_run_reg;
    logic                     scan_pend_reg;
    logic [IDX_W-1:0]         scan_cnt_reg;
    logic [IDX_W-1:0]         scan_idx_reg;
    logic                     best_valid_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic [DL_W-1:0]          best_dl_reg;
    logic [DL_W-1:0]          rd_dl;
    logic                     best_due;

    logic [DL_W-1:0]          dl_sel;
    logic [DL_W-1:0]          div_d;
    logic                     div_busy;
    logic [MS_W-1:0]          div_ms;

    dtq_status_t              res_status_reg;
    logic [MS_W-1:0]          rem_reg;
    logic                     tvalid_reg;
    logic [MS_W-1:0]          tms_reg;
    logic                     wvalid_reg;
    logic [ID_W-1:0]          wtask_reg;
    logic                     m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]   m_tdata_reg;

    assign in_fire  = cmd.in_ready & s_tvalid;
    assign s_tready = cmd.in_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign id_addr  = IDX_W'(id_reg);
    assign now64    = DL_W'(now_reg);
    assign new_dl   = now64 + DL_W'(prod_reg);
    assign rd_dl    = rd_data_reg[DL_W-1:0];
    assign best_due = best_valid_reg && (now64 >= best_dl_reg);
    assign rd_addr  = cmd.look ? id_addr : scan_cnt_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = id_addr;
        wr_data = {1'b0, ent_dl_reg};
        if (cmd.clr_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else if (cmd.set_entry)
        begin
            wr_en   = 1'b1;
            wr_data = {1'b1, new_dl};
        end
        else if (cmd.unwait)
        begin
            wr_en   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg  <= dtq_action_t'(s_tuser);
            id_reg   <= s_tdata[ID_W-1:0];
            now_reg  <= s_tdata[ID_W+DELAY_W+NOW_W-1:ID_W+DELAY_W];
            prod_reg <= PROD_W'(s_tdata[ID_W+DELAY_W-1:ID_W]) * PROD_W'(NS_PER_MS);
        end
        if (cmd.cap_entry)
        begin
            ent_dl_reg <= rd_dl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_wr)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_run_reg   <= 1'b0;
            scan_pend_reg  <= 1'b0;
            scan_cnt_reg   <= '0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            scan_pend_reg <= scan_run_reg;
            if (cmd.scan_start)
            begin
                scan_run_reg   <= 1'b1;
                scan_cnt_reg   <= '0;
                best_valid_reg <= 1'b0;
            end
            else
            begin
                if (scan_run_reg)
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    if (scan_cnt_reg == IDX_W'(TASK_SLOTS - 1))
                    begin
                        scan_run_reg <= 1'b0;
                    end
                end
                if (scan_pend_reg && rd_data_reg[DL_W]
                    && (!best_valid_reg || (rd_dl < best_dl_reg)))
                begin
                    best_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_cnt_reg;
        if (!cmd.scan_start && scan_pend_reg && rd_data_reg[DL_W]
            && (!best_valid_reg || (rd_dl < best_dl_reg)))
        begin
            best_idx_reg <= scan_idx_reg;
            best_dl_reg  <= rd_dl;
        end
    end

    assign dl_sel = (cmd.div_src == SRC_BEST) ? best_dl_reg : ent_dl_reg;
    assign div_d  = (dl_sel > now64) ? (dl_sel - now64) : '0;

    dtq_ms_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .d     (div_d),
        .busy  (div_busy),
        .ms    (div_ms)
    );

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_status_reg <= ST_OK;
            rem_reg        <= '0;
            tvalid_reg     <= 1'b0;
            tms_reg        <= '0;
            wvalid_reg     <= 1'b0;
            wtask_reg      <= '0;
        end
        else
        begin
            if (cmd.set_status)
            begin
                res_status_reg <= cmd.status_code;
            end
            if (cmd.set_tvalid)
            begin
                tvalid_reg <= best_valid_reg;
            end
            if (cmd.set_wake && best_due)
            begin
                wvalid_reg <= 1'b1;
                wtask_reg  <= ID_W'(best_idx_reg);
            end
            if (cmd.store_div)
            begin
                if (act_reg == ACT_END)
                begin
                    rem_reg <= div_ms;
                end
                else
                begin
                    tms_reg <= div_ms;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata_reg <= {7'b0, wtask_reg, wvalid_reg, tms_reg, tvalid_reg,
                            rem_reg, res_status_reg};
        end
    end

    always_comb
    begin
        stat.clr_done    = (clr_cnt_reg == IDX_W'(TASK_SLOTS - 1));
        stat.in_valid    = s_tvalid;
        stat.act         = act_reg;
        stat.in_range    = (32'(id_reg) < TASK_SLOTS);
        stat.ent_waiting = rd_data_reg[DL_W];
        stat.scan_busy   = scan_run_reg | scan_pend_reg;
        stat.was_first   = best_valid_reg && (best_idx_reg == id_addr);
        stat.best_valid  = best_valid_reg;
        stat.div_busy    = div_busy;
        stat.out_free    = !m_tvalid_reg || m_tready;
    end

endmodule

// File: rtl/dtq_ctrl.sv
// Controller state machine of the deadline timer queue: sequences the slot lookup,
// scans, divisions and result hand-off for each action.
// Depends on dtq_pkg; drives the datapath through command and status structs.
module dtq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  dtq_pkg::dtq_stat_t  stat,
    output dtq_pkg::dtq_cmd_t   cmd
);
    import dtq_pkg::*;

    dtq_state_t state_reg;
    dtq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (stat.in_valid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                unique case (stat.act)
                    ACT_START: state_next = S_OUT;
                    ACT_END:
                    begin
                        if (stat.in_range && stat.ent_waiting)
                        begin
                            state_next = S_SCAN1;
                        end
                        else
                        begin
                            state_next = S_OUT;
                        end
                    end
                    ACT_QUERY, ACT_WAKE: state_next = S_SCAN1;
                    default: state_next = S_OUT;
                endcase
            end
            S_SCAN1:
            begin
                if (!stat.scan_busy)
                begin
                    unique case (stat.act)
                        ACT_END:   state_next = stat.was_first ? S_SCAN2 : S_DIV;
                        ACT_QUERY: state_next = stat.best_valid ? S_DIV : S_OUT;
                        ACT_START, ACT_WAKE: state_next = S_OUT;
                        default:   state_next = S_OUT;
                    endcase
                end
            end
            S_SCAN2:
            begin
                if (!stat.scan_busy)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
            end
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
            end
            S_LOOK:
            begin
                cmd.look = 1'b1;
            end
            S_CHECK:
            begin
                unique case (stat.act)
                    ACT_START:
                    begin
                        if (!stat.in_range)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_NOT_WAITING;
                        end
                        else if (stat.ent_waiting)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_ALREADY;
                        end
                        else
                        begin
                            cmd.set_entry = 1'b1;
                        end
                    end
                    ACT_END:
                    begin
                        if (stat.in_range && stat.ent_waiting)
                        begin
                            cmd.cap_entry  = 1'b1;
                            cmd.scan_start = 1'b1;
                        end
                        else
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_NOT_WAITING;
                        end
                    end
                    ACT_QUERY, ACT_WAKE:
                    begin
                        cmd.scan_start = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SCAN1:
            begin
                if (!stat.scan_busy)
                begin
                    unique case (stat.act)
                        ACT_END:
                        begin
                            cmd.unwait     = 1'b1;
                            cmd.div_start  = 1'b1;
                            cmd.div_src    = SRC_ENTRY;
                            cmd.scan_start = stat.was_first;
                        end
                        ACT_QUERY:
                        begin
                            cmd.set_tvalid = 1'b1;
                            cmd.div_start  = stat.best_valid;
                            cmd.div_src    = SRC_BEST;
                        end
                        ACT_WAKE:
                        begin
                            cmd.set_wake = 1'b1;
                        end
                        ACT_START:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN2:
            begin
                if (!stat.scan_busy)
                begin
                    cmd.set_wake = 1'b1;
                end
            end
            S_DIV:
            begin
                if (!stat.div_busy)
                begin
                    cmd.store_div = 1'b1;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: rtl/deadline_timer_queue.sv
// Top level of the deadline timer queue: joins the controller and the datapath.
// Depends on dtq_pkg, dtq_ctrl and dtq_datapath.
//
//   Channel | Direction | Payload
//   s_*     | in        | tuser: action; tdata: task_id, delay_ms, now_ns
//   m_*     | out       | tdata: status, remaining_ms, timeout_valid, timeout_ms,
//           |           |        wake_valid, wake_task
//
// After reset every slot of the table is cleared before s_tready rises.
// One transaction at a time. Start wait and a refused end wait only look up the slot;
// wake check, and query with no task waiting, also scan all slots; query and end wait
// scan, then run the millisecond divider; end wait also rescans the slots when the
// earliest entry is removed.
// A new transaction is taken while the previous result still waits on m_tready.
module deadline_timer_queue #(
    parameter int TASK_SLOTS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // task_id[4:0], delay_ms[36:5], now_ns[99:37], zero pad to 104 bits
    input  logic [dtq_pkg::IN_TDATA_W-1:0]   s_tdata,
    // action[1:0]
    input  logic [dtq_pkg::TUSER_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[1:0], remaining_ms[33:2], timeout_valid[34], timeout_ms[66:35],
    // wake_valid[67], wake_task[72:68], zero pad to 80 bits
    output logic [dtq_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import dtq_pkg::*;

    dtq_cmd_t  cmd;
    dtq_stat_t stat;

    dtq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    dtq_datapath #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: rtl/dtq_checker.sv
// Port-level checks for the deadline timer queue, attached by the bind below.
// Depends on dtq_pkg and the top level deadline_timer_queue.
module dtq_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dtq_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import dtq_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result changed or dropped while stalled.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Second transaction taken while one is in progress.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("Undefined status code on the result.");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[34] && m_tdata[67]))
        else $error("Timeout and wake reported in the same result.");

    a_clean_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[34] || (m_tdata[66:35] == '0))
                  && (m_tdata[67] || (m_tdata[72:68] == '0)))
        else $error("Field set without its valid flag.");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: test/tb_deadline_timer_queue.sv
`timescale 1ns / 1ps
// Self-checking testbench for deadline_timer_queue: directed and random stream traffic,
// with every transaction predicted in the bench and checked on the result stream.
// Depends on dtq_pkg and deadline_timer_queue; reads no files.
module tb_deadline_timer_queue;
    import dtq_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 600;
    localparam logic [62:0] NOW_TOP = {63{1'b1}};

    // Field order follows m_tdata from the top bit down, so a cast unpacks it.
    typedef struct packed {
        logic [4:0]  wake_task;
        logic        wake_valid;
        logic [31:0] timeout_ms;
        logic        timeout_valid;
        logic [31:0] remaining_ms;
        dtq_status_t status;
    } timer_reply_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [TUSER_W-1:0]     s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [63:0]    slot_deadline [32];
    logic [31:0]    slot_busy = '0;
    timer_reply_t   pending_replies [$];
    timer_reply_t   got_reply;
    timer_reply_t   want_reply;
    logic [62:0]    clock_ns = '0;
    int             error_count = 0;
    int             cycle_count = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             hold_ask = 0;
    int             hold_seen = 0;
    int             hold_left = 0;

    deadline_timer_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic int earliest_slot();
        int best;
        best = -1;
        for (int i = 0; i < 32; i++)
        begin
            if (slot_busy[i] && (best < 0 || slot_deadline[i] < slot_deadline[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic logic [31:0] ms_until(logic [62:0] now, logic [63:0] dl);
        logic [63:0] gap;
        logic [63:0] ms;
        if (dl <= {1'b0, now})
            return '0;
        gap = dl - {1'b0, now};
        ms  = gap / 64'(NS_PER_MS) + ((gap % 64'(NS_PER_MS)) != 0 ? 64'd1 : 64'd0);
        return (ms > 64'(MS_MAX)) ? MS_MAX : ms[31:0];
    endfunction

    function automatic timer_reply_t apply_timer_action(dtq_action_t act, logic [4:0] id,
                                                        logic [31:0] dly, logic [62:0] now);
        timer_reply_t r;
        int           e;
        logic         was_first;
        r = '0;
        case (act)
            ACT_START:
            begin
                if (slot_busy[id])
                    r.status = ST_ALREADY;
                else
                begin
                    slot_deadline[id] = {1'b0, now} + 64'(dly) * 64'(NS_PER_MS);
                    slot_busy[id]     = 1'b1;
                end
            end
            ACT_END:
            begin
                if (!slot_busy[id])
                    r.status = ST_NOT_WAITING;
                else
                begin
                    was_first      = (earliest_slot() == int'(id));
                    slot_busy[id]  = 1'b0;
                    r.remaining_ms = ms_until(now, slot_deadline[id]);
                    if (was_first)
                    begin
                        e = earliest_slot();
                        if (e >= 0 && {1'b0, now} >= slot_deadline[e])
                        begin
                            r.wake_valid = 1'b1;
                            r.wake_task  = 5'(e);
                        end
                    end
                end
            end
            ACT_QUERY:
            begin
                e = earliest_slot();
                if (e >= 0)
                begin
                    r.timeout_valid = 1'b1;
                    r.timeout_ms    = ms_until(now, slot_deadline[e]);
                end
            end
            default:
            begin
                e = earliest_slot();
                if (e >= 0 && {1'b0, now} >= slot_deadline[e])
                begin
                    r.wake_valid = 1'b1;
                    r.wake_task  = 5'(e);
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_ask != hold_seen)
        begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_reply = timer_reply_t'(m_tdata[72:0]);
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                error_count++;
            end
            else
            begin
                want_reply = pending_replies.pop_front();
                report_field("status", want_reply.status, got_reply.status);
                report_field("remaining_ms", want_reply.remaining_ms, got_reply.remaining_ms);
                report_field("timeout_valid", want_reply.timeout_valid, got_reply.timeout_valid);
                report_field("timeout_ms", want_reply.timeout_ms, got_reply.timeout_ms);
                report_field("wake_valid", want_reply.wake_valid, got_reply.wake_valid);
                report_field("wake_task", want_reply.wake_task, got_reply.wake_task);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic offer_timer_op(input dtq_action_t act, input logic [4:0] id,
                                  input logic [31:0] dly, input logic [62:0] now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'b0, now, dly, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_replies.push_back(apply_timer_action(act, id, dly, now));
    endtask

    task automatic send_random_op();
        int          pick;
        int          base;
        logic [4:0]  id;
        logic [31:0] dly;
        dtq_action_t act;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            offer_timer_op(dtq_action_t'($urandom_range(3)), 5'($urandom), $urandom,
                           63'({$urandom, $urandom}));
            return;
        end
        pick = $urandom_range(99);
        if (pick < 2)
            clock_ns = 63'({$urandom, $urandom});
        else if (pick < 4)
            clock_ns = clock_ns - 63'(64'($urandom_range(2000)) * 64'(NS_PER_MS));
        else if (pick < 24)
            clock_ns = clock_ns + 63'(64'($urandom_range(400)) * 64'(NS_PER_MS));
        else
            clock_ns = clock_ns + 63'($urandom_range(400_000_000));
        pick = $urandom_range(99);
        if (pick < 85)
            dly = $urandom_range(1000);
        else if (pick < 95)
            dly = $urandom_range(5);
        else
            dly = $urandom;
        id   = 5'($urandom_range(31));
        pick = $urandom_range(99);
        if (pick < 35)
            act = ACT_START;
        else if (pick < 65)
        begin
            act = ACT_END;
            if ($urandom_range(99) < 80)
            begin
                base = $urandom_range(31);
                for (int k = 0; k < 32; k++)
                begin
                    if (slot_busy[(base + k) % 32])
                    begin
                        id = 5'((base + k) % 32);
                        break;
                    end
                end
            end
        end
        else if (pick < 80)
            act = ACT_QUERY;
        else
            act = ACT_WAKE;
        offer_timer_op(act, id, dly, clock_ns);
    endtask

    task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        repeat (count)
            send_random_op();
    endtask

    task automatic test_empty_table();
        offer_timer_op(ACT_QUERY, 5'd0, 32'd0, 63'd0);
        offer_timer_op(ACT_WAKE, 5'd0, 32'd0, NOW_TOP);
        offer_timer_op(ACT_END, 5'd7, 32'd0, 63'd0);
    endtask

    task automatic test_start_and_ties();
        offer_timer_op(ACT_START, 5'd0, 32'd0, 63'd0);
        offer_timer_op(ACT_START, 5'd0, 32'd5, 63'd0);
        offer_timer_op(ACT_START, 5'd31, MS_MAX, NOW_TOP);
        offer_timer_op(ACT_START, 5'd3, 32'd0, 63'd0);
        offer_timer_op(ACT_WAKE, 5'd0, 32'd0, 63'd0);
        offer_timer_op(ACT_QUERY, 5'd0, 32'd0, NOW_TOP);
        offer_timer_op(ACT_END, 5'd0, 32'd0, 63'd0);
        offer_timer_op(ACT_END, 5'd31, 32'd0, 63'd0);
        offer_timer_op(ACT_QUERY, 5'd0, 32'd0, 63'd0);
        offer_timer_op(ACT_END, 5'd3, 32'd0, 63'd0);
    endtask

    task automatic test_rounding();
        offer_timer_op(ACT_START, 5'd9, 32'd1, 63'd1000);
        offer_timer_op(ACT_QUERY, 5'd0, 32'd0, 63'd1001);
        offer_timer_op(ACT_QUERY, 5'd0, 32'd0, 63'd999);
        offer_timer_op(ACT_QUERY, 5'd0, 32'd0, 63'd1001000);
        offer_timer_op(ACT_WAKE, 5'd0, 32'd0, 63'd1000999);
        offer_timer_op(ACT_END, 5'd9, 32'd0, 63'd1);
    endtask

    task automatic test_long_remainder();
        offer_timer_op(ACT_START, 5'd20, MS_MAX, NOW_TOP);
        offer_timer_op(ACT_START, 5'd21, 32'd1, 63'd0);
        offer_timer_op(ACT_QUERY, 5'd0, 32'd0, 63'd0);
        offer_timer_op(ACT_END, 5'd21, 32'd0, 63'd2000000);
        offer_timer_op(ACT_QUERY, 5'd0, 32'd0, 63'd0);
        offer_timer_op(ACT_END, 5'd20, 32'd0, NOW_TOP);
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_ask <= hold_ask + 1;
        repeat (40)
            send_random_op();
    endtask

    task automatic test_random_traffic();
        run_random_phase(500, 0, 0);
        run_random_phase(400, 88, 0);
        test_output_backpressure();
        run_random_phase(400, 0, 88);
        run_random_phase(500, 17, 17);
    endtask

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_start_and_ties();
        test_rounding();
        test_long_remainder();
        test_random_traffic();
        s_tvalid <= 1'b0;
        recv_stall_pct <= 0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
